>>> hdl/bes_pkg.sv
// Package with the item and result word types and the fixed field widths of the event scheduler.
`timescale 1ns / 1ps

package bes_pkg;

	// Fixed field widths.
	localparam int TASK_ID_W   = 3;
	localparam int EVENT_W     = 5;
	localparam int EVENT_COUNT = 32;

	// Item kinds.
	typedef enum logic [1:0] {
		KIND_SET_EVENT = 2'd0,
		KIND_SCHEDULE  = 2'd1,
		KIND_RESUME    = 2'd2,
		KIND_PAUSE     = 2'd3
	} kind_t;

	// Input word.
	typedef struct packed {
		kind_t                kind;
		logic [TASK_ID_W-1:0] task_id;
		logic [EVENT_W-1:0]   event_in;
	} item_word_t;

	// Result word.
	typedef struct packed {
		logic                 found;
		logic [TASK_ID_W-1:0] task_out;
		logic [EVENT_W-1:0]   event_out;
	} result_word_t;

endpackage

>>> hdl/bes_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module bes_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/bitmap_event_scheduler.sv
// Top level of the fixed-priority bitmap event scheduler.
//
//  Channel | Direction | Handshake                  | Word
//  item    | in        | item_valid / item_stall    | kind, task_id, event_in
//  result  | out       | result_valid / result_stall| found, task_out, event_out
//
// Resume and pause words complete at accept. Set-event and schedule words go on to the
// modify state: the task's pending mask, read from the RAM at accept, is modified and
// written back; a schedule word that finds no candidate task completes at accept instead.
// After reset all pending masks read as zero through per-task valid bits; no clearing pass.
// A word is taken only when the block is idle and no result waits on a stalled output.
`timescale 1ns / 1ps

module bitmap_event_scheduler
	import bes_pkg::*;
#(
	parameter int TASK_COUNT = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         item_valid,
	output logic         item_stall,
	input  item_word_t   item,
	output logic         result_valid,
	input  logic         result_stall,
	output result_word_t result
);

	localparam int TASK_W = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;

	typedef enum logic {
		ST_IDLE,
		ST_MODIFY
	} state_t;

	state_t                  state_q;
	kind_t                   op_s1;
	logic [TASK_W-1:0]       task_s1;
	logic [EVENT_W-1:0]      event_s1;
	logic [TASK_COUNT-1:0]   ready_q;
	logic [TASK_COUNT-1:0]   active_q;
	logic [TASK_COUNT-1:0]   pend_vld_q;
	logic                    result_valid_q;
	result_word_t            result_q;

	logic                    accept;
	logic                    task_ok;
	logic [TASK_W-1:0]       item_task;
	logic [TASK_COUNT-1:0]   cand;
	logic [TASK_W-1:0]       cand_sel;
	logic [EVENT_COUNT-1:0]  ram_rdata;
	logic [EVENT_COUNT-1:0]  cur_mask;
	logic [EVENT_COUNT-1:0]  next_mask;
	logic [EVENT_W-1:0]      ev_sel;
	logic                    ram_we;
	logic [TASK_W-1:0]       ram_raddr;
	logic                    result_load;

	// Input handshake: one word at a time, and never over a stalled result.
	assign item_stall = (state_q != ST_IDLE) || (result_valid_q && result_stall);
	assign accept     = item_valid && !item_stall;
	assign item_task  = item.task_id[TASK_W-1:0];
	assign task_ok    = ({1'b0, item.task_id} < (TASK_ID_W+1)'(TASK_COUNT));

	// Lowest-numbered task that is both ready and active.
	assign cand = ready_q & active_q;
	always_comb begin
		cand_sel = '0;
		for (int i = TASK_COUNT - 1; i >= 0; i--) begin
			if (cand[i]) begin
				cand_sel = TASK_W'(i);
			end
		end
	end

	// Pending-mask read: schedule reads the chosen task, set-event the named one.
	assign ram_raddr = (item.kind == KIND_SCHEDULE) ? cand_sel : item_task;

	// A task whose mask was never written reads as empty.
	assign cur_mask = pend_vld_q[task_s1] ? ram_rdata : '0;

	// Lowest pending event of the current mask.
	always_comb begin
		ev_sel = '0;
		for (int i = EVENT_COUNT - 1; i >= 0; i--) begin
			if (cur_mask[i]) begin
				ev_sel = EVENT_W'(i);
			end
		end
	end

	// Modified mask: raise the event bit, or clear the picked one.
	always_comb begin
		if (op_s1 == KIND_SET_EVENT) begin
			next_mask = cur_mask | (EVENT_COUNT'(1) << event_s1);
		end else begin
			next_mask = cur_mask & ~(EVENT_COUNT'(1) << ev_sel);
		end
	end

	assign ram_we = (state_q == ST_MODIFY) &&
		((op_s1 == KIND_SET_EVENT) || (cur_mask != '0));

	// A result is loaded by an empty schedule at accept or by a schedule's modify cycle.
	assign result_load = (accept && (item.kind == KIND_SCHEDULE) && (cand == '0)) ||
		((state_q == ST_MODIFY) && (op_s1 != KIND_SET_EVENT));

	bes_ram #(
		.WIDTH (EVENT_COUNT),
		.DEPTH (TASK_COUNT)
	) u_pend_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (task_s1),
		.wdata (next_mask),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Sequencer, masks and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			ready_q        <= '0;
			active_q       <= '0;
			pend_vld_q     <= '0;
			result_valid_q <= 1'b0;
			op_s1          <= KIND_SET_EVENT;
			task_s1        <= '0;
			event_s1       <= '0;
			result_q       <= '0;
		end else begin
			if (result_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_s1    <= item.kind;
						task_s1  <= ram_raddr;
						event_s1 <= item.event_in;
						unique case (item.kind)
							KIND_SET_EVENT: begin
								if (task_ok) begin
									state_q <= ST_MODIFY;
								end
							end
							KIND_RESUME: begin
								if (task_ok) begin
									active_q[item_task] <= 1'b1;
								end
							end
							KIND_PAUSE: begin
								if (task_ok) begin
									active_q[item_task] <= 1'b0;
								end
							end
							KIND_SCHEDULE: begin
								if (cand == '0) begin
									result_q <= '0;
								end else begin
									state_q <= ST_MODIFY;
								end
							end
							default: ;
						endcase
					end
				end
				ST_MODIFY: begin
					pend_vld_q[task_s1] <= 1'b1;
					if (op_s1 == KIND_SET_EVENT) begin
						ready_q[task_s1] <= 1'b1;
					end else begin
						if (cur_mask == '0) begin
							ready_q[task_s1] <= 1'b0;
							result_q         <= '0;
						end else begin
							if (next_mask == '0) begin
								ready_q[task_s1] <= 1'b0;
							end
							result_q.found     <= 1'b1;
							result_q.task_out  <= TASK_ID_W'(task_s1);
							result_q.event_out <= ev_sel;
						end
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// A task is only ever ready once its pending mask has been written.
	a_ready_has_mask: assert property (@(posedge clk) disable iff (!arst_n)
		(ready_q & ~pend_vld_q) == '0)
		else $error("ready task without a written pending mask");

	// The result slot is free whenever a schedule word reaches its modify cycle.
	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MODIFY && op_s1 == KIND_SCHEDULE) |-> !result_valid_q)
		else $error("schedule result would overwrite a pending result");

	// The modify cycle always addresses a task within the task count.
	a_task_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MODIFY) |-> ({1'b0, task_s1} < (TASK_W+1)'(TASK_COUNT)))
		else $error("modify cycle addresses a task beyond the task count");

	// A schedule word entering the modify cycle had a ready and active candidate.
	a_sched_cand: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.kind == KIND_SCHEDULE && cand != '0) |=>
		(state_q == ST_MODIFY && ready_q[task_s1]))
		else $error("scheduled task is not ready");

endmodule
